>>> hdl/bud_pkg.sv
// Shared types and constants for the BOM-detecting text decoder.
// No dependencies; compile first.
`default_nettype none

package bud_pkg;

  localparam int CpW     = 21;
  localparam int PosOutW = 32;

  // result status codes
  localparam logic [1:0] StatusChar    = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusEnd     = 2'd2;

  // text encodings
  localparam logic [1:0] EncUtf8    = 2'd0;
  localparam logic [1:0] EncUtf16Be = 2'd1;
  localparam logic [1:0] EncUtf16Le = 2'd2;

  // byte-order mark bytes
  localparam logic [7:0] ByteFe = 8'hFE;
  localparam logic [7:0] ByteFf = 8'hFF;
  localparam logic [7:0] ByteEf = 8'hEF;
  localparam logic [7:0] ByteBb = 8'hBB;
  localparam logic [7:0] ByteBf = 8'hBF;

  // UTF-16 surrogate tags (unit bits 15:10, any-surrogate tag bits 15:11) and supplementary base
  localparam logic [5:0]     SurrHighTag = 6'b110110;
  localparam logic [5:0]     SurrLowTag  = 6'b110111;
  localparam logic [4:0]     SurrAnyTag  = 5'b11011;
  localparam logic [CpW-1:0] SuppBase    = 21'h10000;

  localparam logic [CpW-1:0] CharCr = 21'h0D;
  localparam logic [CpW-1:0] CharLf = 21'h0A;

  typedef struct packed {
    logic [CpW-1:0]     code_point;
    logic [1:0]         status;
    logic [PosOutW-1:0] row;
    logic [PosOutW-1:0] column;
    logic [PosOutW-1:0] offset;
    logic [1:0]         encoding;
    logic               last_of_run;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/bud_in_if.sv
// Input channel of the text decoder: one raw byte or an end mark per word.
// Depends on bud_pkg.
`default_nettype none

interface bud_in_if;
  import bud_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

`default_nettype wire

>>> hdl/bud_out_if.sv
// Output channel of the text decoder: one decoded character with position per word.
// Depends on bud_pkg.
`default_nettype none

interface bud_out_if;
  import bud_pkg::*;

  logic               valid;
  logic               ready;
  logic [CpW-1:0]     code_point;
  logic [1:0]         status;
  logic [PosOutW-1:0] row;
  logic [PosOutW-1:0] column;
  logic [PosOutW-1:0] offset;
  logic [1:0]         encoding;
  logic               last_of_run;

  modport source (output valid, output code_point, output status, output row,
                  output column, output offset, output encoding, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input status, input row,
                  input column, input offset, input encoding, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/bom_utf_decoder_with_position.sv
// BOM-detecting UTF-8 / UTF-16 decoder with row, column and offset tracking.
// Results are registered in the output queue. Throughput: one byte per cycle while at
//   most one word waits; a byte or end mark that breaks an unfinished mark can give two
//   results, which the 3-entry output queue drains one per cycle while out_o.ready is
//   high, holding input off meanwhile. Depends on bud_pkg, bud_in_if, bud_out_if.
// Reset (rst_ni low, async): mark search restarts, encoding UTF-8, counters zero,
//   output queue empty.
`default_nettype none

module bom_utf_decoder_with_position #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bud_in_if.sink    in_i,
  bud_out_if.source out_o
);
  import bud_pkg::*;

  localparam int PosW = int'(POSITION_BITS);
  localparam int ExtW = (PosW > PosOutW) ? PosW : PosOutW;

  // mark search stages
  localparam logic [2:0] StageStart = 3'd0;
  localparam logic [2:0] StageFe    = 3'd1;
  localparam logic [2:0] StageFf    = 3'd2;
  localparam logic [2:0] StageEf    = 3'd3;
  localparam logic [2:0] StageEfbb  = 3'd4;
  localparam logic [2:0] StageDone  = 3'd5;

  // ---------------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------------
  logic [2:0]      stage_q, stage_d;
  logic [1:0]      enc_q, enc_d;
  logic [CpW-1:0]  part_q, part_d;     // UTF-8 partial value
  logic [1:0]      rem_q, rem_d;       // UTF-8 continuation bytes still due
  logic [8:0]      pend_q, pend_d;     // UTF-16 first byte, bit 8 = held
  logic [10:0]     hs_q, hs_d;         // high surrogate, bit 10 = held
  logic            cr_q, cr_d;         // last character was CR
  logic [PosW-1:0] row_q, row_d;
  logic [PosW-1:0] col_q, col_d;
  logic [PosW-1:0] off_q, off_d;

  logic       accept;
  logic [7:0] b;
  logic       in_end;

  assign accept = in_i.valid && in_i.ready;
  assign b      = in_i.data_byte;
  assign in_end = in_i.end_marker;

  // ---------------------------------------------------------------------------
  // One-pass step: mark search, held-byte replay, decode and position update.
  // A broken mark can replay FE or FF (an invalid lead) ahead of the current
  // byte, so a step gives an optional invalid word plus at most one main word.
  // ---------------------------------------------------------------------------
  logic            matched;
  logic            pre_inv;
  logic            do_feed;
  logic            do_end;
  logic [CpW-1:0]  eff_part;
  logic [1:0]      eff_rem;
  logic            is_char;
  logic [CpW-1:0]  char_cp;
  logic [CpW-1:0]  shifted;
  logic [15:0]     unit;
  logic            main_vld;
  logic [1:0]      main_st;
  logic            newline;

  always_comb begin
    stage_d  = stage_q;
    enc_d    = enc_q;
    part_d   = part_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    hs_d     = hs_q;
    cr_d     = cr_q;
    row_d    = row_q;
    col_d    = col_q;
    off_d    = off_q;
    matched  = 1'b0;
    pre_inv  = 1'b0;
    do_feed  = 1'b0;
    do_end   = 1'b0;
    eff_part = part_q;
    eff_rem  = rem_q;
    is_char  = 1'b0;
    char_cp  = '0;
    shifted  = '0;
    unit     = '0;
    main_vld = 1'b0;
    main_st  = StatusChar;
    newline  = 1'b0;

    if (stage_q != StageDone) begin
      // replayed prefix: FE / FF are invalid leads, EF and EF BB open a 3-byte form
      pre_inv = (stage_q == StageFe) || (stage_q == StageFf);
      if (stage_q == StageEf) begin
        eff_rem  = 2'd2;
        eff_part = CpW'(ByteEf[3:0]);
      end else if (stage_q == StageEfbb) begin
        eff_rem  = 2'd1;
        eff_part = CpW'({ByteEf[3:0], ByteBb[5:0]});
      end

      if (in_end) begin
        enc_d   = EncUtf8;
        stage_d = StageDone;
        do_end  = 1'b1;
      end else begin
        unique case (stage_q)
          StageStart: begin
            if (b == ByteFe) begin
              matched = 1'b1;
              stage_d = StageFe;
            end else if (b == ByteFf) begin
              matched = 1'b1;
              stage_d = StageFf;
            end else if (b == ByteEf) begin
              matched = 1'b1;
              stage_d = StageEf;
            end
          end
          StageFe: begin
            if (b == ByteFf) begin
              matched = 1'b1;
              stage_d = StageDone;
              enc_d   = EncUtf16Be;
            end
          end
          StageFf: begin
            if (b == ByteFe) begin
              matched = 1'b1;
              stage_d = StageDone;
              enc_d   = EncUtf16Le;
            end
          end
          StageEf: begin
            if (b == ByteBb) begin
              matched = 1'b1;
              stage_d = StageEfbb;
            end
          end
          default: begin
            if (b == ByteBf) begin
              matched = 1'b1;
              stage_d = StageDone;
              enc_d   = EncUtf8;
            end
          end
        endcase

        if (matched) begin
          pre_inv = 1'b0;
        end else begin
          enc_d   = EncUtf8;
          stage_d = StageDone;
          part_d  = eff_part;
          rem_d   = eff_rem;
          do_feed = 1'b1;
        end
      end
    end else if (in_end) begin
      do_end = 1'b1;
    end else begin
      do_feed = 1'b1;
    end

    if (do_end) begin
      part_d   = '0;
      rem_d    = '0;
      pend_d   = '0;
      hs_d     = '0;
      main_vld = 1'b1;
      main_st  = StatusEnd;
    end

    if (do_feed) begin
      if (enc_d == EncUtf8) begin
        if (eff_rem == 2'd0) begin
          if (b[7] == 1'b0) begin
            is_char = 1'b1;
            char_cp = CpW'(b);
          end else if (b[7:5] == 3'b110) begin
            part_d = CpW'(b[4:0]);
            rem_d  = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            part_d = CpW'(b[3:0]);
            rem_d  = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            part_d = CpW'(b[2:0]);
            rem_d  = 2'd3;
          end else begin
            main_vld = 1'b1;
            main_st  = StatusInvalid;
          end
        end else begin
          shifted = {eff_part[CpW-7:0], b[5:0]};
          rem_d   = eff_rem - 2'd1;
          if (eff_rem == 2'd1) begin
            is_char = 1'b1;
            char_cp = shifted;
            part_d  = '0;
          end else begin
            part_d = shifted;
          end
        end
      end else begin
        if (!pend_q[8]) begin
          pend_d = {1'b1, b};
        end else begin
          pend_d = '0;
          unit   = (enc_d == EncUtf16Le) ? {b, pend_q[7:0]} : {pend_q[7:0], b};
          if (hs_q[10]) begin
            hs_d = '0;
            if (unit[15:10] == SurrLowTag) begin
              is_char = 1'b1;
              char_cp = {1'b0, hs_q[9:0], unit[9:0]} + SuppBase;
            end else begin
              main_vld = 1'b1;
              main_st  = StatusInvalid;
            end
          end else if (unit[15:11] != SurrAnyTag) begin
            is_char = 1'b1;
            char_cp = CpW'(unit);
          end else if (unit[15:10] == SurrHighTag) begin
            hs_d = {1'b1, unit[9:0]};
          end else begin
            main_vld = 1'b1;
            main_st  = StatusInvalid;
          end
        end
      end
    end

    // position update for a decoded character, saturating counters
    if (is_char) begin
      main_vld = 1'b1;
      main_st  = StatusChar;
      newline  = (char_cp == CharCr) || ((char_cp == CharLf) && !cr_q);
      if (newline) begin
        row_d = (row_q == '1) ? row_q : row_q + 1'b1;
        col_d = '0;
      end else begin
        col_d = (col_q == '1) ? col_q : col_q + 1'b1;
      end
      off_d = (off_q == '1) ? off_q : off_q + 1'b1;
      cr_d  = (char_cp == CharCr);
    end
  end

  // ---------------------------------------------------------------------------
  // Result words for this step
  // ---------------------------------------------------------------------------
  logic [ExtW-1:0] row_cur_x, col_cur_x, off_cur_x;
  logic [ExtW-1:0] row_nxt_x, col_nxt_x, off_nxt_x;
  res_t            inv_res, main_res, first_res;
  logic [1:0]      n_res;

  assign row_cur_x = ExtW'(row_q);
  assign col_cur_x = ExtW'(col_q);
  assign off_cur_x = ExtW'(off_q);
  assign row_nxt_x = ExtW'(row_d);
  assign col_nxt_x = ExtW'(col_d);
  assign off_nxt_x = ExtW'(off_d);

  always_comb begin
    inv_res.code_point  = '0;
    inv_res.status      = StatusInvalid;
    inv_res.row         = row_cur_x[PosOutW-1:0];
    inv_res.column      = col_cur_x[PosOutW-1:0];
    inv_res.offset      = off_cur_x[PosOutW-1:0];
    inv_res.encoding    = enc_d;
    inv_res.last_of_run = !main_vld;

    main_res.code_point  = is_char ? char_cp : '0;
    main_res.status      = main_st;
    main_res.row         = row_nxt_x[PosOutW-1:0];
    main_res.column      = col_nxt_x[PosOutW-1:0];
    main_res.offset      = off_nxt_x[PosOutW-1:0];
    main_res.encoding    = enc_d;
    main_res.last_of_run = 1'b1;

    first_res = pre_inv ? inv_res : main_res;
    n_res     = {1'b0, pre_inv} + {1'b0, main_vld};
  end

  // ---------------------------------------------------------------------------
  // Output queue: 3 words, head at entry 0. Input is taken while at most one
  // word waits, so a two-word step always fits.
  // ---------------------------------------------------------------------------
  res_t       q_q [3];
  res_t       q_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] base;

  assign pop = (cnt_q != 2'd0) && out_o.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < 2; i++) begin
        q_d[i] = q_q[i + 1];
      end
    end
    base  = cnt_q - {1'b0, pop};
    cnt_d = base;
    if (accept) begin
      if (n_res != 2'd0) begin
        q_d[base] = first_res;
      end
      if (n_res == 2'd2) begin
        q_d[base + 2'd1] = main_res;
      end
      cnt_d = base + n_res;
    end
  end

  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1);

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.code_point  = q_q[0].code_point;
  assign out_o.status      = q_q[0].status;
  assign out_o.row         = q_q[0].row;
  assign out_o.column      = q_q[0].column;
  assign out_o.offset      = q_q[0].offset;
  assign out_o.encoding    = q_q[0].encoding;
  assign out_o.last_of_run = q_q[0].last_of_run;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StageStart;
      enc_q   <= EncUtf8;
      part_q  <= '0;
      rem_q   <= '0;
      pend_q  <= '0;
      hs_q    <= '0;
      cr_q    <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      off_q   <= '0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        stage_q <= stage_d;
        enc_q   <= enc_d;
        part_q  <= part_d;
        rem_q   <= rem_d;
        pend_q  <= pend_d;
        hs_q    <= hs_d;
        cr_q    <= cr_d;
        row_q   <= row_d;
        col_q   <= col_d;
        off_q   <= off_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an end word always produces at least one result
  a_end_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_end) |=> (cnt_q != 2'd0))
    else $error("end word left no result queued");

  // a held high surrogate only exists in UTF-16 mode
  a_hs_utf16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_q[10] |-> (enc_q != EncUtf8))
    else $error("high surrogate held in UTF-8 mode");

  // UTF-8 continuation count only runs in UTF-8 mode
  a_rem_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 2'd0) |-> (enc_q == EncUtf8))
    else $error("UTF-8 sequence open in UTF-16 mode");

  // while the mark is undecided no decode state is held
  a_mark_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q != StageDone) |-> ((rem_q == 2'd0) && !pend_q[8] && !hs_q[10]))
    else $error("decode state held during mark search");

  // end and invalid words carry a zero code point
  a_noncode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != StatusChar)) |-> (out_o.code_point == '0))
    else $error("non-character word with nonzero code point");

endmodule

`default_nettype wire
